// ----- hw/rtl/spc_pkg.sv -----
`default_nettype none

package spc_pkg;

	// Width of a whole-degree hysteresis limit.
	localparam int LIMIT_WIDTH = 7;

	// Fixed temperature thresholds in whole degrees.
	localparam int POOL_MAX_DEG     = 33;
	localparam int AUX_MAX_DEG      = 58;
	localparam int DIFF_DHW_DEG     = 8;
	localparam int DIFF_WINTER_DEG  = 9;
	localparam int POOL_GAP_DEG     = 12;
	localparam int DIFF_AUX_DEG     = 14;

	// Bit positions in the pump drive word.
	localparam int PUMP_DHW  = 0;
	localparam int PUMP_POOL = 1;
	localparam int PUMP_AUX  = 2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_AUTO_ENABLE    = 2'd0;
	localparam logic [1:0] REG_PRIORITY_MODE  = 2'd1;
	localparam logic [1:0] REG_DHW_LOW_LIMIT  = 2'd2;
	localparam logic [1:0] REG_DHW_HIGH_LIMIT = 2'd3;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_WINTER = 2'd1,
		MODE_POOL   = 2'd2,
		MODE_NO_AUX = 2'd3
	} mode_t;

	typedef struct packed {
		logic                   auto_enable;
		mode_t                  priority_mode;
		logic [LIMIT_WIDTH-1:0] dhw_low_limit;
		logic [LIMIT_WIDTH-1:0] dhw_high_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0]             drive;
		logic                   last_dhw_seen;
		logic [LIMIT_WIDTH-1:0] dhw_limit;
	} ctl_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/spc_if.sv -----
`default_nettype none

interface spc_sample_if #(
	parameter int TEMP_WIDTH = 12
);
	logic                         valid;
	logic                         ready;
	logic signed [TEMP_WIDTH-1:0] collector_temp;
	logic signed [TEMP_WIDTH-1:0] dhw_tank_temp;
	logic signed [TEMP_WIDTH-1:0] pool_temp;
	logic signed [TEMP_WIDTH-1:0] aux_tank_temp;

	modport source (
		output valid, collector_temp, dhw_tank_temp, pool_temp, aux_tank_temp,
		input  ready
	);
	modport sink (
		input  valid, collector_temp, dhw_tank_temp, pool_temp, aux_tank_temp,
		output ready
	);
endinterface

interface spc_result_if;
	import spc_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   dhw_pump_on;
	logic                   pool_pump_on;
	logic                   aux_pump_on;
	logic [LIMIT_WIDTH-1:0] dhw_limit_used;

	modport source (
		output valid, dhw_pump_on, pool_pump_on, aux_pump_on, dhw_limit_used,
		input  ready
	);
	modport sink (
		input  valid, dhw_pump_on, pool_pump_on, aux_pump_on, dhw_limit_used,
		output ready
	);
endinterface

`default_nettype wire

// ----- hw/rtl/spc_decide.sv -----
`default_nettype none

module spc_decide #(
	parameter int TEMP_WIDTH = 12
) (
	input  wire logic signed [TEMP_WIDTH-1:0] collector_temp,
	input  wire logic signed [TEMP_WIDTH-1:0] dhw_tank_temp,
	input  wire logic signed [TEMP_WIDTH-1:0] pool_temp,
	input  wire logic signed [TEMP_WIDTH-1:0] aux_tank_temp,
	input  wire spc_pkg::cfg_t                cfg,
	input  wire spc_pkg::ctl_state_t          cur,
	output      spc_pkg::ctl_state_t          nxt
);
	import spc_pkg::*;

	// One extra bit keeps the differences exact.
	localparam int W = TEMP_WIDTH + 1;

	localparam logic signed [W-1:0] POOL_MAX    = W'(POOL_MAX_DEG * 16);
	localparam logic signed [W-1:0] AUX_MAX     = W'(AUX_MAX_DEG * 16);
	localparam logic signed [W-1:0] DIFF_DHW    = W'(DIFF_DHW_DEG * 16);
	localparam logic signed [W-1:0] DIFF_WINTER = W'(DIFF_WINTER_DEG * 16);
	localparam logic signed [W-1:0] POOL_GAP    = W'(POOL_GAP_DEG * 16);
	localparam logic signed [W-1:0] DIFF_AUX    = W'(DIFF_AUX_DEG * 16);

	logic signed [W-1:0]    coll_x, tank_x, pool_x, aux_x, lim_x;
	logic signed [W-1:0]    d_tank, d_pool, d_aux;
	logic                   dhw_now;
	logic [LIMIT_WIDTH-1:0] limit_new;
	logic                   tank_cold, pool_cold, aux_cold;
	logic                   want_dhw, want_pool, want_aux;
	logic [2:0]             drive_new;

	always_comb begin
		dhw_now = cur.drive[PUMP_DHW];
		if (dhw_now != cur.last_dhw_seen) begin
			limit_new = dhw_now ? cfg.dhw_high_limit : cfg.dhw_low_limit;
		end else begin
			limit_new = cur.dhw_limit;
		end

		coll_x = {collector_temp[TEMP_WIDTH-1], collector_temp};
		tank_x = {dhw_tank_temp[TEMP_WIDTH-1], dhw_tank_temp};
		pool_x = {pool_temp[TEMP_WIDTH-1], pool_temp};
		aux_x  = {aux_tank_temp[TEMP_WIDTH-1], aux_tank_temp};
		lim_x  = {{(W - LIMIT_WIDTH - 4){1'b0}}, limit_new, 4'b0000};

		d_tank = coll_x - tank_x;
		d_pool = coll_x - pool_x;
		d_aux  = coll_x - aux_x;

		tank_cold = tank_x < lim_x;
		pool_cold = pool_x < POOL_MAX;
		aux_cold  = aux_x < AUX_MAX;

		case (cfg.priority_mode)
			MODE_NORMAL: begin
				want_dhw  = tank_cold && (d_tank > DIFF_DHW);
				want_pool = pool_cold && (d_pool > POOL_GAP);
				want_aux  = aux_cold && (d_aux > DIFF_AUX);
			end
			MODE_WINTER: begin
				want_dhw  = tank_cold && (d_tank > DIFF_WINTER);
				want_pool = 1'b0;
				want_aux  = aux_cold && (d_aux > DIFF_WINTER);
			end
			MODE_POOL: begin
				want_dhw  = 1'b0;
				want_pool = pool_cold && (d_pool > DIFF_WINTER);
				want_aux  = aux_cold && (d_aux > DIFF_WINTER);
			end
			default: begin
				want_dhw  = tank_cold && (d_tank > DIFF_DHW);
				want_pool = pool_cold && (d_pool > POOL_GAP);
				want_aux  = 1'b0;
			end
		endcase

		drive_new = 3'b000;
		if (want_dhw) begin
			drive_new[PUMP_DHW] = 1'b1;
		end else if (want_pool) begin
			drive_new[PUMP_POOL] = 1'b1;
		end else if (want_aux) begin
			drive_new[PUMP_AUX] = 1'b1;
		end

		nxt.drive         = cfg.auto_enable ? drive_new : cur.drive;
		nxt.last_dhw_seen = dhw_now;
		nxt.dhw_limit     = limit_new;
	end

endmodule

`default_nettype wire

// ----- hw/rtl/solar_pump_priority_controller.sv -----
`default_nettype none

// Channel   Direction  Transfer contents
// in_ch     sink       collector, hot-water tank, pool, aux tank temperatures
// out_ch    source     three pump drives and the hysteresis limit in use
// APB       slave      four control registers at byte addresses 0, 4, 8, 12
//
// A sample set is captured in the input register, decided combinationally and
// written to the result register; one transfer per cycle is sustained in both
// directions while out_ch.ready stays high, so throughput is one item per clock.
// The controller state (pump drive, last hot-water drive, limit) updates when an
// item moves into the result register, so each item sees its predecessor's state.
// A stalled result register holds the input register, and in_ch.ready drops only
// when both hold an item. Reset loads the register defaults and turns all pumps off.
module solar_pump_priority_controller #(
	parameter int TEMP_WIDTH = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	spc_sample_if.sink       in_ch,
	spc_result_if.source     out_ch
);
	import spc_pkg::*;

	// Configuration registers.
	cfg_t cfg_q;

	// Input register: one sample set waiting to be decided.
	logic                         valid_s1;
	logic signed [TEMP_WIDTH-1:0] coll_s1, tank_s1, pool_s1, aux_s1;

	// Controller state carried from item to item.
	ctl_state_t state_q, state_next;

	// Result register.
	logic                   out_valid_q;
	logic [2:0]             out_drive_q;
	logic [LIMIT_WIDTH-1:0] out_limit_q;

	logic advance;
	logic cfg_write;

	// The input stage moves on when the result register is empty or being drained.
	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// APB: zero wait states, the write lands in the access phase.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_enable    <= 1'b1;
			cfg_q.priority_mode  <= MODE_NORMAL;
			cfg_q.dhw_low_limit  <= LIMIT_WIDTH'(50);
			cfg_q.dhw_high_limit <= LIMIT_WIDTH'(58);
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_AUTO_ENABLE:    cfg_q.auto_enable    <= pwdata[0];
				REG_PRIORITY_MODE:  cfg_q.priority_mode  <= mode_t'(pwdata[1:0]);
				REG_DHW_LOW_LIMIT:  cfg_q.dhw_low_limit  <= pwdata[LIMIT_WIDTH-1:0];
				REG_DHW_HIGH_LIMIT: cfg_q.dhw_high_limit <= pwdata[LIMIT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_AUTO_ENABLE:    prdata[0] = cfg_q.auto_enable;
			REG_PRIORITY_MODE:  prdata[1:0] = cfg_q.priority_mode;
			REG_DHW_LOW_LIMIT:  prdata[LIMIT_WIDTH-1:0] = cfg_q.dhw_low_limit;
			REG_DHW_HIGH_LIMIT: prdata[LIMIT_WIDTH-1:0] = cfg_q.dhw_high_limit;
			default:            prdata = '0;
		endcase
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// Sample payload carries no reset.
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			coll_s1 <= in_ch.collector_temp;
			tank_s1 <= in_ch.dhw_tank_temp;
			pool_s1 <= in_ch.pool_temp;
			aux_s1  <= in_ch.aux_tank_temp;
		end
	end

	spc_decide #(
		.TEMP_WIDTH(TEMP_WIDTH)
	) u_decide (
		.collector_temp(coll_s1),
		.dhw_tank_temp (tank_s1),
		.pool_temp     (pool_s1),
		.aux_tank_temp (aux_s1),
		.cfg           (cfg_q),
		.cur           (state_q),
		.nxt           (state_next)
	);

	// Controller state: pumps off, last hot-water drive seen as on, limit zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.drive         <= 3'b000;
			state_q.last_dhw_seen <= 1'b1;
			state_q.dhw_limit     <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_drive_q <= state_next.drive;
			out_limit_q <= state_next.dhw_limit;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.dhw_pump_on    = out_drive_q[PUMP_DHW];
	assign out_ch.pool_pump_on   = out_drive_q[PUMP_POOL];
	assign out_ch.aux_pump_on    = out_drive_q[PUMP_AUX];
	assign out_ch.dhw_limit_used = out_limit_q;

	// Never more than one pump runs.
	a_one_pump: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(state_q.drive))
		else $error("more than one pump driven");

	// With automatic control off the drives are frozen.
	a_hold_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !cfg_q.auto_enable) |=> (state_q.drive == $past(state_q.drive)))
		else $error("pump drive changed with automatic control off");

	// The limit moves only on a hot-water drive edge.
	a_limit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (state_q.drive[PUMP_DHW] == state_q.last_dhw_seen))
		|=> (state_q.dhw_limit == $past(state_q.dhw_limit)))
		else $error("hysteresis limit changed without a pump edge");

	// A stalled result stays valid and keeps its contents.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ch.ready) |=> (out_valid_q && $stable(out_drive_q)
			&& $stable(out_limit_q)))
		else $error("result register lost data while stalled");

endmodule

`default_nettype wire

// ----- sim/solar_pump_priority_controller_tb.sv -----
`default_nettype none

module solar_pump_priority_controller_tb;
	import spc_pkg::*;

	localparam int TEMP_WIDTH = 12;
	localparam int TEMP_MAX = 2047;
	localparam int TEMP_MIN = -2048;
	// Temperatures on the bus are in sixteenths of a degree.
	localparam int SIXTEENTHS = 16;
	localparam int DIRECTED_ROWS = 33;

	typedef struct packed {
		logic signed [TEMP_WIDTH-1:0] collector_temp;
		logic signed [TEMP_WIDTH-1:0] dhw_tank_temp;
		logic signed [TEMP_WIDTH-1:0] pool_temp;
		logic signed [TEMP_WIDTH-1:0] aux_tank_temp;
	} sample_t;

	typedef struct packed {
		logic                   dhw_pump_on;
		logic                   pool_pump_on;
		logic                   aux_pump_on;
		logic [LIMIT_WIDTH-1:0] dhw_limit_used;
	} pump_result_t;

	typedef enum logic {
		ROW_SAMPLE = 1'b0,
		ROW_WRITE  = 1'b1
	} row_kind_t;

	// One row of the directed table. A sample row may carry a typed-in result;
	// otherwise the pump model supplies the expected result.
	typedef struct packed {
		row_kind_t    kind;
		logic [1:0]   reg_idx;
		logic [31:0]  wdata;
		sample_t      smp;
		logic         has_want;
		pump_result_t want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	spc_sample_if #(.TEMP_WIDTH(TEMP_WIDTH)) sample_ch();
	spc_result_if result_ch();

	solar_pump_priority_controller #(
		.TEMP_WIDTH(TEMP_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_ch(sample_ch),
		.out_ch(result_ch)
	);

	// Shadow copies of the control registers, updated on each write, and of the
	// controller state, which advances once per accepted sample, in transfer order.
	cfg_t         cfg_shadow;
	ctl_state_t   ctl_model;
	pump_result_t pending_results[$];
	pump_result_t oldest_result;
	int           mismatch_count;
	int           tx_idle_pct;
	int           rx_idle_pct;
	stim_row_t    directed_rows [0:DIRECTED_ROWS-1];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Works out the pump drives and the hysteresis limit for one sample set.
	// The limit follows the hot-water drive left by the previous sample: a drop
	// loads the low limit, a rise loads the high limit. The pumps are decided
	// afterwards, and with automatic control off the drives simply hold.
	function automatic pump_result_t predict_pumps(sample_t smp);
		int           coll;
		int           tank;
		int           pool;
		int           aux;
		int           lim;
		logic         dhw_now;
		logic         want_dhw;
		logic         want_pool;
		logic         want_aux;
		logic [2:0]   next_drive;
		pump_result_t res;
		coll = smp.collector_temp;
		tank = smp.dhw_tank_temp;
		pool = smp.pool_temp;
		aux = smp.aux_tank_temp;
		dhw_now = ctl_model.drive[PUMP_DHW];
		if (dhw_now != ctl_model.last_dhw_seen)
			ctl_model.dhw_limit = dhw_now ? cfg_shadow.dhw_high_limit : cfg_shadow.dhw_low_limit;
		ctl_model.last_dhw_seen = dhw_now;
		lim = int'(ctl_model.dhw_limit) * SIXTEENTHS;

		if (cfg_shadow.auto_enable) begin
			case (cfg_shadow.priority_mode)
				MODE_WINTER: begin
					want_dhw = tank < lim && coll - tank > DIFF_WINTER_DEG * SIXTEENTHS;
					want_pool = 1'b0;
					want_aux = aux < AUX_MAX_DEG * SIXTEENTHS
						&& coll - aux > DIFF_WINTER_DEG * SIXTEENTHS;
				end
				MODE_POOL: begin
					want_dhw = 1'b0;
					want_pool = pool < POOL_MAX_DEG * SIXTEENTHS
						&& coll - pool > DIFF_WINTER_DEG * SIXTEENTHS;
					want_aux = aux < AUX_MAX_DEG * SIXTEENTHS
						&& coll - aux > DIFF_WINTER_DEG * SIXTEENTHS;
				end
				default: begin
					// Normal and aux-disabled share the ladder; the latter drops its last rung.
					want_dhw = tank < lim && coll - tank > DIFF_DHW_DEG * SIXTEENTHS;
					want_pool = pool < POOL_MAX_DEG * SIXTEENTHS
						&& coll - pool > POOL_GAP_DEG * SIXTEENTHS;
					want_aux = cfg_shadow.priority_mode != MODE_NO_AUX
						&& aux < AUX_MAX_DEG * SIXTEENTHS
						&& coll - aux > DIFF_AUX_DEG * SIXTEENTHS;
				end
			endcase
			next_drive = '0;
			if (want_dhw)
				next_drive[PUMP_DHW] = 1'b1;
			else if (want_pool)
				next_drive[PUMP_POOL] = 1'b1;
			else if (want_aux)
				next_drive[PUMP_AUX] = 1'b1;
			ctl_model.drive = next_drive;
		end

		res.dhw_pump_on = ctl_model.drive[PUMP_DHW];
		res.pool_pump_on = ctl_model.drive[PUMP_POOL];
		res.aux_pump_on = ctl_model.drive[PUMP_AUX];
		res.dhw_limit_used = ctl_model.dhw_limit;
		return res;
	endfunction

	// Packs four temperatures, given in sixteenths, into one sample set.
	function automatic sample_t mk_sample(int coll, int tank, int pool, int aux);
		sample_t smp;
		smp.collector_temp = TEMP_WIDTH'(coll);
		smp.dhw_tank_temp = TEMP_WIDTH'(tank);
		smp.pool_temp = TEMP_WIDTH'(pool);
		smp.aux_tank_temp = TEMP_WIDTH'(aux);
		return smp;
	endfunction

	function automatic int clamp_temp(int value);
		if (value > TEMP_MAX)
			return TEMP_MAX;
		if (value < TEMP_MIN)
			return TEMP_MIN;
		return value;
	endfunction

	// Half the time a value close to a threshold, otherwise a plausible
	// temperature between about -10 and 100 degrees.
	function automatic int near_temp(int center);
		if ($urandom_range(1) == 1)
			return clamp_temp(center + int'($urandom_range(32)) - 16);
		return int'($urandom_range(1760)) - 160;
	endfunction

	function automatic logic [LIMIT_WIDTH-1:0] pick_limit();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return LIMIT_WIDTH'($urandom_range(100));
		endcase
	endfunction

	// Most sample sets sit near the decision thresholds, with the collector a
	// little above one of the targets, so the comparisons flip often and the
	// hot-water hysteresis keeps toggling. The rest is raw noise over every bit.
	function automatic sample_t random_sample();
		sample_t smp;
		int      anchor;
		int      tank_center;
		if ($urandom_range(99) < 15) begin
			smp.collector_temp = TEMP_WIDTH'($urandom());
			smp.dhw_tank_temp = TEMP_WIDTH'($urandom());
			smp.pool_temp = TEMP_WIDTH'($urandom());
			smp.aux_tank_temp = TEMP_WIDTH'($urandom());
			return smp;
		end
		tank_center = SIXTEENTHS * int'($urandom_range(1) == 1 ?
			cfg_shadow.dhw_high_limit : cfg_shadow.dhw_low_limit);
		smp.dhw_tank_temp = TEMP_WIDTH'(near_temp(tank_center));
		smp.pool_temp = TEMP_WIDTH'(near_temp(POOL_MAX_DEG * SIXTEENTHS));
		smp.aux_tank_temp = TEMP_WIDTH'(near_temp(AUX_MAX_DEG * SIXTEENTHS));
		case ($urandom_range(2))
			0: anchor = smp.dhw_tank_temp;
			1: anchor = smp.pool_temp;
			default: anchor = smp.aux_tank_temp;
		endcase
		smp.collector_temp = TEMP_WIDTH'(clamp_temp(anchor + int'($urandom_range(320)) - 64));
		return smp;
	endfunction

	// Setup phase then access phase; the register takes the data at the edge
	// that ends the access phase.
	task automatic write_reg(logic [1:0] idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_AUTO_ENABLE: cfg_shadow.auto_enable = data[0];
			REG_PRIORITY_MODE: cfg_shadow.priority_mode = mode_t'(data[1:0]);
			REG_DHW_LOW_LIMIT: cfg_shadow.dhw_low_limit = data[LIMIT_WIDTH-1:0];
			default: cfg_shadow.dhw_high_limit = data[LIMIT_WIDTH-1:0];
		endcase
	endtask

	// Offers one sample set, after a random number of idle cycles, and files
	// the expected result once the transfer has happened.
	task automatic send_sample(sample_t smp, logic has_want, pump_result_t want);
		pump_result_t predicted;
		while ($urandom_range(99) < tx_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.collector_temp <= smp.collector_temp;
		sample_ch.dhw_tank_temp <= smp.dhw_tank_temp;
		sample_ch.pool_temp <= smp.pool_temp;
		sample_ch.aux_tank_temp <= smp.aux_tank_temp;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
		predicted = predict_pumps(smp);
		pending_results.push_back(has_want ? want : predicted);
	endtask

	// Holds the input side quiet until every expected result has come back,
	// then lets the two-stage pipeline settle.
	task automatic wait_results_drained();
		sample_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_field(string field, int want, int got);
		if (want != got) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		end
	endtask

	// The receiver drops ready at random according to the current phase.
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Every result transfer is held against the oldest expected result.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: result transfer with no expected result, expected none, %s %0d %0d %0d %0d",
					$time, "actual", result_ch.dhw_pump_on, result_ch.pool_pump_on,
					result_ch.aux_pump_on, result_ch.dhw_limit_used);
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("dhw_pump_on", oldest_result.dhw_pump_on, result_ch.dhw_pump_on);
				check_field("pool_pump_on", oldest_result.pool_pump_on, result_ch.pool_pump_on);
				check_field("aux_pump_on", oldest_result.aux_pump_on, result_ch.aux_pump_on);
				check_field("dhw_limit_used", oldest_result.dhw_limit_used,
					result_ch.dhw_limit_used);
			end
		end
	end

	// Ends a run that hangs and reports it as failed.
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		logic [31:0] word;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sample_ch.valid = 1'b0;
		sample_ch.collector_temp = '0;
		sample_ch.dhw_tank_temp = '0;
		sample_ch.pool_temp = '0;
		sample_ch.aux_tank_temp = '0;
		result_ch.ready = 1'b0;
		mismatch_count = 0;
		tx_idle_pct = 10;
		rx_idle_pct = 58;

		// State after reset: defaults in the registers, pumps off, hot-water
		// drive taken as previously on, so the first sample loads the low limit.
		cfg_shadow = '{1'b1, MODE_NORMAL, 7'd50, 7'd58};
		ctl_model = '{3'b000, 1'b1, 7'd0};

		// Directed table. The first rows run from reset with the default settings
		// and carry typed-in results. Then come the exact edges of every strict
		// compare in the normal ladder, each priority mode, automatic control off
		// (written with junk above bit 0), and limits at both ends of their range
		// written with junk in the upper bits.
		directed_rows = '{
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(2047, -2048, -2048, -2048),
				1'b1, '{1'b1, 1'b0, 1'b0, 7'd50}},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(-2048, 2047, 2047, 2047),
				1'b1, '{1'b0, 1'b0, 1'b0, 7'd58}},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(0, 0, 0, 0),
				1'b1, '{1'b0, 1'b0, 1'b0, 7'd50}},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(2047, 2047, -2048, 2047),
				1'b1, '{1'b0, 1'b1, 1'b0, 7'd50}},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(2047, 2047, 2047, -2048),
				1'b1, '{1'b0, 1'b0, 1'b1, 7'd50}},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(928, 799, 2047, 2047), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(927, 799, 2047, 2047), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(2047, 800, 2047, 2047), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(720, 2047, 527, 2047), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(719, 2047, 527, 2047), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(1152, 2047, 2047, 927), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(2047, 2047, 2047, 928), 1'b0, '0},
			'{ROW_WRITE, REG_PRIORITY_MODE, 32'(MODE_WINTER), '0, 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(145, 0, -2048, 2047), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(145, 2047, -2048, 0), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(144, 2047, 2047, 0), 1'b0, '0},
			'{ROW_WRITE, REG_PRIORITY_MODE, 32'(MODE_POOL), '0, 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(145, -2048, 0, 2047), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(145, -2048, 2047, 0), 1'b0, '0},
			'{ROW_WRITE, REG_PRIORITY_MODE, 32'(MODE_NO_AUX), '0, 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(2047, 2047, 2047, -2048), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(2047, 2047, -2048, -2048), 1'b0, '0},
			'{ROW_WRITE, REG_AUTO_ENABLE, 32'hFFFF_FFFE, '0, 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(2047, -2048, -2048, -2048), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(-2048, 2047, 2047, 2047), 1'b0, '0},
			'{ROW_WRITE, REG_AUTO_ENABLE, 32'd1, '0, 1'b0, '0},
			'{ROW_WRITE, REG_DHW_LOW_LIMIT, 32'hFFFF_FF80, '0, 1'b0, '0},
			'{ROW_WRITE, REG_DHW_HIGH_LIMIT, 32'hABCD_EF7F, '0, 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(2047, -2048, 2047, 2047), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(2047, 2031, 2047, 2047), 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(-2048, -2048, -2048, -2048), 1'b0, '0},
			'{ROW_WRITE, REG_PRIORITY_MODE, 32'(MODE_NORMAL), '0, 1'b0, '0},
			'{ROW_SAMPLE, REG_AUTO_ENABLE, 32'd0, mk_sample(2047, 2047, 2047, 2047), 1'b0, '0}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Register writes only happen with the pipeline empty.
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_results_drained();
				write_reg(directed_rows[i].reg_idx, directed_rows[i].wdata);
			end else begin
				send_sample(directed_rows[i].smp, directed_rows[i].has_want,
					directed_rows[i].want);
			end
		end

		// Random part in three idling phases: sender idles lightly while the
		// receiver stalls heavily, then the reverse, then full rate. Each phase
		// walks through several register settings; the mode steps through all
		// four values, and every write carries random bits above the field.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 10;
					rx_idle_pct = 58;
				end
				1: begin
					tx_idle_pct = 58;
					rx_idle_pct = 10;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int blk = 0; blk < 6; blk++) begin
				wait_results_drained();
				word = $urandom();
				word[0] = ($urandom_range(99) < 85);
				write_reg(REG_AUTO_ENABLE, word);
				word = $urandom();
				word[1:0] = 2'(blk + phase);
				write_reg(REG_PRIORITY_MODE, word);
				word = $urandom();
				word[LIMIT_WIDTH-1:0] = pick_limit();
				write_reg(REG_DHW_LOW_LIMIT, word);
				word = $urandom();
				word[LIMIT_WIDTH-1:0] = pick_limit();
				write_reg(REG_DHW_HIGH_LIMIT, word);
				repeat (61) send_sample(random_sample(), 1'b0, '0);
			end
		end

		wait_results_drained();
		repeat (6) @(posedge clk);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
